>>> sv/nfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfst_pkg: shared types and constants of the next-fit slot table
// Transfer payloads, command classes and status codes.
// ----------------------------------------------------------------------------
package nfst_pkg;

	localparam int SLOTS_DEF       = 1024;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 16;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_GET    = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HANDLE_W-1:0] buffer_handle;
		logic [SLOT_W-1:0]   slot;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_out;
		logic [HANDLE_W-1:0] handle_out;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_DELETE,
		KIND_GET,
		KIND_EMPTY
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_status_t;

endpackage

>>> sv/nfst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfst_queue: small synchronous FIFO
// Register-based queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module nfst_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/nfst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfst_front: request classifier
// Sorts each request into add, delete, get or an immediate empty answer.
// ----------------------------------------------------------------------------
module nfst_front #(
	parameter int SLOTS = 1024
) (
	input  nfst_pkg::in_item_t item,
	output nfst_pkg::cmd_t     cmd
);
	import nfst_pkg::*;

	logic in_range;

	assign in_range = (32'(item.slot) < 32'(SLOTS));

	always_comb begin
		cmd.handle = item.buffer_handle;
		cmd.slot   = item.slot;
		case (item.operation)
			OP_ADD:    cmd.kind = KIND_ADD;
			OP_DELETE: cmd.kind = in_range ? KIND_DELETE : KIND_EMPTY;
			OP_GET:    cmd.kind = in_range ? KIND_GET : KIND_EMPTY;
			default:   cmd.kind = KIND_EMPTY;
		endcase
	end

endmodule

>>> sv/nfst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfst_back: slot table engine
// Holds the occupancy rows and handle store, runs the next-fit row scan.
// ----------------------------------------------------------------------------
module nfst_back #(
	parameter int SLOTS       = 1024,
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_empty,
	input  nfst_pkg::cmd_t         cmd,
	output logic                   cmd_pop,
	input  logic                   res_full,
	output logic                   res_push,
	output nfst_pkg::out_item_t    res,
	output nfst_pkg::back_status_t stat
);
	import nfst_pkg::*;

	localparam int RB        = (SLOTS >= 32) ? 32 : (1 << $clog2(SLOTS));
	localparam int ROWS      = (SLOTS + RB - 1) / RB;
	localparam int BW        = $clog2(RB);
	localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW        = RW + BW;
	localparam int VW        = $clog2(ROWS + 1);
	localparam int LAST_BITS = SLOTS - (ROWS - 1) * RB;
	localparam int HW        = (HANDLE_BITS > HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int SW        = (AW > SLOT_W) ? AW : SLOT_W;
	localparam logic [RB-1:0] LAST_MASK = {RB{1'b1}} >> (RB - LAST_BITS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_OUT
	} state_t;

	logic [RB-1:0]          occ_mem [ROWS];
	logic [HANDLE_BITS-1:0] hnd_mem [ROWS * RB];

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [RW-1:0]          row_q;
	logic [BW-1:0]          start_bit_q;
	logic [VW-1:0]          visits_q;
	logic [AW-1:0]          last_q;
	logic [RW-1:0]          clr_row_q;
	out_item_t              res_q;
	logic [RB-1:0]          occ_rd_q;
	logic [HANDLE_BITS-1:0] hnd_rd_q;

	logic [AW-1:0]          next_slot;
	logic [AW-1:0]          cmd_addr;
	logic [AW-1:0]          cmd_q_addr;
	logic [RW-1:0]          row_next;
	logic                   last_visit;
	logic [RB-1:0]          lo_mask;
	logic [RB-1:0]          win_mask;
	logic [RB-1:0]          row_mask;
	logic [RB-1:0]          cand;
	logic                   found;
	logic [BW-1:0]          found_bit;
	logic                   hit;
	logic                   occ_re;
	logic [RW-1:0]          occ_raddr;
	logic                   occ_we;
	logic [RW-1:0]          occ_waddr;
	logic [RB-1:0]          occ_wdata;
	logic                   hnd_re;
	logic                   hnd_we;
	logic [HW-1:0]          hnd_in_w;
	logic [HW-1:0]          hnd_out_w;
	logic [SW-1:0]          found_slot_w;

	assign next_slot  = (last_q == AW'(SLOTS - 1)) ? '0 : last_q + 1'b1;
	assign cmd_addr   = AW'(cmd.slot);
	assign cmd_q_addr = AW'(cmd_q.slot);
	assign row_next   = (row_q == RW'(ROWS - 1)) ? '0 : row_q + 1'b1;
	assign last_visit = (visits_q == VW'(ROWS));
	assign lo_mask    = {RB{1'b1}} << start_bit_q;
	assign row_mask   = (row_q == RW'(ROWS - 1)) ? LAST_MASK : {RB{1'b1}};
	assign win_mask   = (visits_q == '0) ? lo_mask : (last_visit ? ~lo_mask : {RB{1'b1}});
	assign cand       = ~occ_rd_q & row_mask & win_mask;
	assign found      = |cand;
	assign hit        = occ_rd_q[cmd_q_addr[BW-1:0]];
	assign hnd_in_w   = HW'(cmd_q.handle);
	assign hnd_out_w  = HW'(hnd_rd_q);
	assign found_slot_w = SW'({row_q, found_bit});

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res      = res_q;
	assign stat.clearing = (state_q == S_CLEAR);
	assign stat.busy     = (state_q != S_IDLE);

	always_comb begin
		found_bit = '0;
		for (int i = RB - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found_bit = BW'(i);
			end
		end
	end

	always_comb begin
		occ_re    = 1'b0;
		occ_raddr = '0;
		hnd_re    = 1'b0;
		if (cmd_pop) begin
			case (cmd.kind)
				KIND_ADD: begin
					occ_re    = 1'b1;
					occ_raddr = next_slot[AW-1:BW];
				end
				KIND_DELETE, KIND_GET: begin
					occ_re    = 1'b1;
					occ_raddr = cmd_addr[AW-1:BW];
					hnd_re    = 1'b1;
				end
				default: begin
					occ_re = 1'b0;
				end
			endcase
		end else if (state_q == S_SCAN && !found && !last_visit) begin
			occ_re    = 1'b1;
			occ_raddr = row_next;
		end
	end

	always_comb begin
		occ_we    = 1'b0;
		occ_waddr = '0;
		occ_wdata = '0;
		hnd_we    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				occ_we    = 1'b1;
				occ_waddr = clr_row_q;
			end
			S_LOOK: begin
				occ_we    = hit && (cmd_q.kind == KIND_DELETE);
				occ_waddr = cmd_q_addr[AW-1:BW];
				occ_wdata = occ_rd_q & ~(RB'(1) << cmd_q_addr[BW-1:0]);
			end
			S_SCAN: begin
				occ_we    = found;
				occ_waddr = row_q;
				occ_wdata = occ_rd_q | (RB'(1) << found_bit);
				hnd_we    = found;
			end
			default: begin
				occ_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		if (occ_re) begin
			occ_rd_q <= occ_mem[occ_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hnd_we) begin
			hnd_mem[{row_q, found_bit}] <= hnd_in_w[HANDLE_BITS-1:0];
		end
		if (hnd_re) begin
			hnd_rd_q <= hnd_mem[cmd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_row_q   <= '0;
			last_q      <= AW'(SLOTS - 1);
			row_q       <= '0;
			start_bit_q <= '0;
			visits_q    <= '0;
			cmd_q       <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == RW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						case (cmd.kind)
							KIND_ADD: begin
								row_q       <= next_slot[AW-1:BW];
								start_bit_q <= next_slot[BW-1:0];
								visits_q    <= '0;
								state_q     <= S_SCAN;
							end
							KIND_DELETE, KIND_GET: begin
								state_q <= S_LOOK;
							end
							default: begin
								res_q.status     <= STATUS_EMPTY;
								res_q.slot_out   <= cmd.slot;
								res_q.handle_out <= '0;
								state_q          <= S_OUT;
							end
						endcase
					end
				end
				S_LOOK: begin
					res_q.slot_out   <= cmd_q.slot;
					res_q.status     <= hit ? STATUS_OK : STATUS_EMPTY;
					res_q.handle_out <= hit ? hnd_out_w[HANDLE_W-1:0] : '0;
					state_q          <= S_OUT;
				end
				S_SCAN: begin
					if (found) begin
						last_q           <= {row_q, found_bit};
						res_q.status     <= STATUS_OK;
						res_q.slot_out   <= found_slot_w[SLOT_W-1:0];
						res_q.handle_out <= '0;
						state_q          <= S_OUT;
					end else if (last_visit) begin
						res_q.status     <= STATUS_FULL;
						res_q.slot_out   <= '0;
						res_q.handle_out <= '0;
						state_q          <= S_OUT;
					end else begin
						row_q    <= row_next;
						visits_q <= visits_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/next_fit_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slot_table: packet-buffer handle table with next-fit allocation
// Add stores a handle in the next free slot after the last one filled,
// delete frees a slot and returns its handle, get reads a slot.
//
//   channel   ports                      transfer when
//   request   push, full, request        push && !full
//   response  pop, empty, response       pop && !empty
//
// Occupancy is kept in rows of 32 slots; an add scans one row per cycle.
// Get/delete pass through a lookup state before the response; an out-of-range
// or invalid request goes straight to the response; an add scans up to
// ROWS = ceil(SLOTS/32) rows, revisiting its start row for the low bits.
// After reset a clearing pass over all ROWS occupancy rows holds full high.
// Two-entry queues on both sides let requests and responses stall on their own.
// ----------------------------------------------------------------------------
module next_fit_slot_table #(
	parameter int SLOTS       = nfst_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = nfst_pkg::HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  nfst_pkg::in_item_t  request,
	output logic                empty,
	input  logic                pop,
	output nfst_pkg::out_item_t response
);
	import nfst_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(out_item_t);

	cmd_t         front_cmd;
	logic [CMD_W-1:0] cmd_rdata;
	logic         cmd_full;
	logic         cmd_empty;
	logic         cmd_pop;
	logic         res_full;
	logic         res_push;
	out_item_t    back_res;
	logic [RES_W-1:0] res_rdata;
	back_status_t back_stat;

	assign full     = cmd_full || back_stat.clearing;
	assign response = out_item_t'(res_rdata);

	nfst_front #(
		.SLOTS(SLOTS)
	) u_front (
		.item(request),
		.cmd (front_cmd)
	);

	nfst_queue #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata (front_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	nfst_back #(
		.SLOTS      (SLOTS),
		.HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_t'(cmd_rdata)),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res),
		.stat     (back_stat)
	);

	nfst_queue #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("response pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty && !back_stat.busy)
		else $error("command taken while engine busy or queue empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> !back_stat.clearing)
		else $error("request transfer during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !back_stat.busy || back_stat.clearing == 1'b0)
		else $error("engine did not return after response push");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the next-fit slot table
// Drives add, delete, get and invalid requests through the request queue
// and checks every response against a behavioral table with its own
// occupancy map, handle store and next-fit pointer. Covers a directed
// opening, a long run of adds across several rows, a release storm and a
// random mix, with bursts of idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	import nfst_pkg::*;

	class slot_table_scoreboard;
		bit                  occupied [SLOTS_DEF];
		logic [HANDLE_W-1:0] handles [SLOTS_DEF];
		int                  last_filled;
		int                  errors;
		out_item_t           expected_responses [$];

		function new();
			foreach (occupied[i])
				occupied[i] = 1'b0;
			last_filled = SLOTS_DEF - 1;
			errors      = 0;
		endfunction

		function out_item_t predict_response(in_item_t req);
			out_item_t rsp;
			int        idx;
			bit        found;
			rsp.status     = STATUS_EMPTY;
			rsp.slot_out   = req.slot;
			rsp.handle_out = '0;
			found          = 1'b0;
			if (req.operation == OP_ADD) begin
				rsp.status   = STATUS_FULL;
				rsp.slot_out = '0;
				idx          = last_filled;
				for (int k = 0; k < SLOTS_DEF && !found; k++) begin
					idx = (idx + 1) % SLOTS_DEF;
					if (!occupied[idx]) begin
						found         = 1'b1;
						occupied[idx] = 1'b1;
						handles[idx]  = req.buffer_handle;
						last_filled   = idx;
						rsp.status   = STATUS_OK;
						rsp.slot_out = idx[SLOT_W-1:0];
					end
				end
			end else if ((req.operation == OP_DELETE || req.operation == OP_GET) &&
					int'(req.slot) < SLOTS_DEF && occupied[req.slot]) begin
				rsp.status     = STATUS_OK;
				rsp.handle_out = handles[req.slot];
				if (req.operation == OP_DELETE)
					occupied[req.slot] = 1'b0;
			end
			return rsp;
		endfunction

		function void note_request(in_item_t req);
			expected_responses.push_back(predict_response(req));
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			if (expected_responses.size() == 0) begin
				$error("response with no request waiting: status %0d slot %0d handle %0h",
					got.status, got.slot_out, got.handle_out);
				errors++;
				return;
			end
			want = expected_responses.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.slot_out !== want.slot_out) begin
				$error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
				errors++;
			end
			if (got.handle_out !== want.handle_out) begin
				$error("handle_out: expected %0h, actual %0h", want.handle_out,
					got.handle_out);
				errors++;
			end
		endfunction

		function int pending();
			return expected_responses.size();
		endfunction

		function int pick_occupied(int start);
			int idx;
			for (int k = 0; k < SLOTS_DEF; k++) begin
				idx = (start + k) % SLOTS_DEF;
				if (occupied[idx])
					return idx;
			end
			return start;
		endfunction
	endclass

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  request;
	logic      empty;
	logic      pop;
	out_item_t response;
	bit        calm;

	slot_table_scoreboard table_sb;

	next_fit_slot_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
			input logic [SLOT_W-1:0] slot);
		in_item_t req;
		req.operation     = op;
		req.buffer_handle = handle;
		req.slot          = slot;
		push    <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (full);
		table_sb.note_request(req);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic random_request();
		int pick;
		int slot;
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, SLOTS_DEF - 1);
		if ($urandom_range(0, 3) != 0)
			slot = table_sb.pick_occupied(slot);
		maybe_pause();
		if (pick < 35)
			send_request(OP_ADD, HANDLE_W'($urandom_range(0, 65535)),
				SLOT_W'($urandom_range(0, 1023)));
		else if (pick < 65)
			send_request(OP_DELETE, HANDLE_W'($urandom_range(0, 65535)), SLOT_W'(slot));
		else if (pick < 95)
			send_request(OP_GET, HANDLE_W'($urandom_range(0, 65535)), SLOT_W'(slot));
		else
			send_request(OP_UNUSED, HANDLE_W'($urandom_range(0, 65535)), SLOT_W'(slot));
	endtask

	initial begin
		int stall;
		pop   = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				table_sb.check_response(response);
			if (calm) begin
				pop <= 1'b1;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if ($urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(0, 11);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#1000000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		table_sb = new();
		calm     = 1'b0;
		arst_n   = 1'b0;
		push     = 1'b0;
		request  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_ADD, 16'h0000, 10'h3FF);
		send_request(OP_ADD, 16'hFFFF, 10'h000);
		send_request(OP_GET, 16'h0000, 10'd0);
		send_request(OP_GET, 16'hFFFF, 10'd1);
		send_request(OP_GET, 16'h0000, 10'h3FF);
		send_request(OP_DELETE, 16'h0000, 10'd1);
		send_request(OP_DELETE, 16'hFFFF, 10'd1);
		send_request(OP_GET, 16'h0000, 10'd1);
		send_request(OP_UNUSED, 16'h0000, 10'd0);
		send_request(OP_UNUSED, 16'hFFFF, 10'h3FF);
		send_request(OP_ADD, 16'hA5A5, 10'h2AA);
		send_request(OP_ADD, 16'h5A5A, 10'h155);
		send_request(OP_DELETE, 16'h0000, 10'd0);
		send_request(OP_GET, 16'h0000, 10'd2);
		send_request(OP_DELETE, 16'h0000, 10'h3FF);
		send_request(OP_GET, 16'h0000, 10'h2AA);
		send_request(OP_GET, 16'h0000, 10'h155);
		send_request(OP_DELETE, 16'h0000, 10'd3);
		send_request(OP_ADD, 16'h1234, 10'd0);

		// fill a run of slots across several rows
		repeat (150) begin
			maybe_pause();
			send_request(OP_ADD, HANDLE_W'($urandom_range(0, 65535)),
				SLOT_W'($urandom_range(0, 1023)));
		end
		repeat (20) random_request();

		// hold until every response has been taken
		push <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);

		repeat (60) begin
			maybe_pause();
			send_request(OP_DELETE, HANDLE_W'($urandom_range(0, 65535)),
				SLOT_W'(table_sb.pick_occupied($urandom_range(0, SLOTS_DEF - 1))));
		end

		repeat (100) random_request();
		calm = 1'b1;
		repeat (50) random_request();

		push <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (table_sb.errors == 0 && table_sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
